// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while the active-low reset is asserted.
`define JDM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Same-cycle implication.
`define JDM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ----- rtl/core/jdm_pkg.sv -----
// Shared types and constants of the joystick drive mixer.
`timescale 1ns / 1ps
package jdm_pkg;

    localparam int unsigned GAIN_W  = 11;
    localparam int unsigned AXIS_W  = 11;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned A_W     = 48;
    localparam int unsigned Q1_W    = 30;
    localparam int unsigned SQ_W    = 22;
    localparam int unsigned N_CELLS = 8;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 11'd256;
    localparam logic [0:0] REG_TURN_GAIN = 1'b0;

    typedef enum logic [1:0] {
        DIR_RELEASE  = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } dir_t;

    // Per-wheel partial state handed from cell to cell.
    typedef struct packed {
        logic [A_W-1:0]     a;   // (m*|num|)^2 >> 16
        logic [A_W-1:0]     s;   // q^2 * sq
        logic [Q1_W-1:0]    q1;  // q * sq
        logic [SQ_W-1:0]    sq;  // X^2 + Y^2
        logic [SPEED_W-1:0] q;
    } wheel_t;

    typedef struct packed {
        logic brush;
        logic zero;
        logic pos_l;
        logic pos_r;
    } side_t;

endpackage

// ----- rtl/core/jdm_front.sv -----
// Front stages: axis negation, magnitudes, mix numerators and squared targets.
`timescale 1ns / 1ps
module jdm_front (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [jdm_pkg::AXIS_W-1:0] x_in,
    input  logic signed [jdm_pkg::AXIS_W-1:0] y_in,
    input  logic                              brush_in,
    input  logic [jdm_pkg::GAIN_W-1:0]        gain,
    output jdm_pkg::wheel_t                   left_out,
    output jdm_pkg::wheel_t                   right_out,
    output jdm_pkg::side_t                    side_out
);
    logic signed [11:0] xs, ys;
    logic [10:0] ax, ay;
    logic signed [22:0] turn_w;

    logic [10:0]        m1_reg;
    logic [21:0]        sq1_reg;
    logic signed [19:0] base1_reg;
    logic signed [22:0] turn1_reg;
    logic               brush1_reg;

    logic signed [23:0] numl, numr;
    logic [23:0] magl, magr;
    logic [34:0] nl_w, nr_w;

    logic [31:0] nl2_reg, nr2_reg;
    logic [21:0] sq2_reg;
    jdm_pkg::side_t side2_reg;

    logic [63:0] al_w, ar_w;
    jdm_pkg::wheel_t left_reg, right_reg;
    jdm_pkg::side_t side3_reg;

    assign xs = -{x_in[10], x_in};
    assign ys = -{y_in[10], y_in};
    assign ax = xs[11] ? 11'(-xs) : xs[10:0];
    assign ay = ys[11] ? 11'(-ys) : ys[10:0];
    assign turn_w = 23'(xs * $signed({1'b0, gain}));

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg     <= (ax > ay) ? ax : ay;
            sq1_reg    <= 22'(ax * ax) + 22'(ay * ay);
            base1_reg  <= {{8{ys[11]}}, ys} <<< 8;
            turn1_reg  <= turn_w;
            brush1_reg <= brush_in;
        end
    end

    assign numl = 24'(base1_reg) + 24'(turn1_reg);
    assign numr = 24'(base1_reg) - 24'(turn1_reg);
    assign magl = numl[23] ? 24'(-numl) : numl;
    assign magr = numr[23] ? 24'(-numr) : numr;
    assign nl_w = 35'({24'd0, m1_reg} * {11'd0, magl});
    assign nr_w = 35'({24'd0, m1_reg} * {11'd0, magr});

    always_ff @(posedge aclk) begin
        if (en) begin
            nl2_reg         <= nl_w[31:0];
            nr2_reg         <= nr_w[31:0];
            sq2_reg         <= sq1_reg;
            side2_reg.brush <= brush1_reg;
            side2_reg.zero  <= (m1_reg == 11'd0);
            side2_reg.pos_l <= !numl[23] && (numl != 24'sd0);
            side2_reg.pos_r <= !numr[23] && (numr != 24'sd0);
        end
    end

    assign al_w = {32'd0, nl2_reg} * {32'd0, nl2_reg};
    assign ar_w = {32'd0, nr2_reg} * {32'd0, nr2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            left_reg.a   <= al_w[63:16];
            left_reg.s   <= '0;
            left_reg.q1  <= '0;
            left_reg.sq  <= sq2_reg;
            left_reg.q   <= '0;
            right_reg.a  <= ar_w[63:16];
            right_reg.s  <= '0;
            right_reg.q1 <= '0;
            right_reg.sq <= sq2_reg;
            right_reg.q  <= '0;
            side3_reg    <= side2_reg;
        end
    end

    assign left_out  = left_reg;
    assign right_out = right_reg;
    assign side_out  = side3_reg;
endmodule

// ----- rtl/core/jdm_cell.sv -----
// One cell of the quotient chain: settles one bit of a wheel speed.
`timescale 1ns / 1ps
module jdm_cell (
    input  logic            aclk,
    input  logic            en,
    input  logic [2:0]      bit_idx,
    input  jdm_pkg::wheel_t w_in,
    output jdm_pkg::wheel_t w_out
);
    logic [49:0] cand;
    logic        take;
    jdm_pkg::wheel_t w_next, w_reg;

    // (q+b)^2*sq = q^2*sq + 2*b*q*sq + b^2*sq
    assign cand = {2'b0, w_in.s}
                + ({20'd0, w_in.q1} << ({1'b0, bit_idx} + 4'd1))
                + ({28'd0, w_in.sq} << {bit_idx, 1'b0});
    assign take = (cand <= {2'b0, w_in.a});

    always_comb begin
        w_next = w_in;
        if (take) begin
            w_next.s  = cand[47:0];
            w_next.q1 = w_in.q1 + ({8'd0, w_in.sq} << bit_idx);
            w_next.q  = w_in.q | (8'd1 << bit_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign w_out = w_reg;
endmodule

// ----- rtl/core/joystick_differential_drive_mixer_unit.sv -----
// Top level of the joystick differential drive mixer.
//
//  channel  | direction | fields (low bit up)
//  s_       | in        | x_position, y_position, brush_on
//  m_       | out       | left/right speed+direction, brush speed+direction
//  apb      | in/out    | turn_gain at byte address 0
//
// One request per cycle while the result is not stalled; three front stages, then eight
// chain cells that each settle one speed bit for both wheels.
// A stalled result holds the whole pipeline; s_tready follows it.
// Reset clears stage valid bits and sets turn_gain to 256.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module joystick_differential_drive_mixer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x_position[10:0], y_position[21:11], brush_on[22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_speed, left_direction, right_speed,
                                   // right_direction, brush_speed, brush_direction
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned DEPTH = 3 + jdm_pkg::N_CELLS;

    logic en;
    logic [jdm_pkg::GAIN_W-1:0] gain_reg;
    logic [DEPTH-1:0] vld_reg;
    jdm_pkg::wheel_t lw [jdm_pkg::N_CELLS+1];
    jdm_pkg::wheel_t rw [jdm_pkg::N_CELLS+1];
    jdm_pkg::side_t  side_front;
    jdm_pkg::side_t  side_reg [jdm_pkg::N_CELLS];
    jdm_pkg::side_t  so;
    logic [7:0] ls, rs;
    jdm_pkg::dir_t ld, rd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == jdm_pkg::REG_TURN_GAIN && paddr[1:0] == 2'd0)
                  ? {21'd0, gain_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= jdm_pkg::GAIN_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == jdm_pkg::REG_TURN_GAIN) begin
            gain_reg <= pwdata[10:0];
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    jdm_front u_front (
        .aclk      (aclk),
        .en        (en),
        .x_in      (s_tdata[10:0]),
        .y_in      (s_tdata[21:11]),
        .brush_in  (s_tdata[22]),
        .gain      (gain_reg),
        .left_out  (lw[0]),
        .right_out (rw[0]),
        .side_out  (side_front)
    );

    for (genvar i = 0; i < jdm_pkg::N_CELLS; i++) begin : g_cell
        jdm_cell u_left (
            .aclk    (aclk),
            .en      (en),
            .bit_idx (3'(jdm_pkg::N_CELLS - 1 - i)),
            .w_in    (lw[i]),
            .w_out   (lw[i+1])
        );
        jdm_cell u_right (
            .aclk    (aclk),
            .en      (en),
            .bit_idx (3'(jdm_pkg::N_CELLS - 1 - i)),
            .w_in    (rw[i]),
            .w_out   (rw[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= (i == 0) ? side_front : side_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign so = side_reg[jdm_pkg::N_CELLS-1];

    // centered stick forces release; the chain would otherwise saturate
    always_comb begin
        ls = so.zero ? 8'd0 : lw[jdm_pkg::N_CELLS].q;
        rs = so.zero ? 8'd0 : rw[jdm_pkg::N_CELLS].q;
        ld = (ls == 8'd0) ? jdm_pkg::DIR_RELEASE
           : (so.pos_l ? jdm_pkg::DIR_FORWARD : jdm_pkg::DIR_BACKWARD);
        rd = (rs == 8'd0) ? jdm_pkg::DIR_RELEASE
           : (so.pos_r ? jdm_pkg::DIR_FORWARD : jdm_pkg::DIR_BACKWARD);
    end

    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = {3'd0, so.brush,
                       (so.brush ? jdm_pkg::SPEED_MAX : 8'd0),
                       rd, rs, ld, ls};

    `JDM_ASSERT(a_ready_follows_out, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `JDM_ASSERT_IMPL(a_left_release, aclk, aresetn, m_tvalid && m_tdata[9:8] == jdm_pkg::DIR_RELEASE, m_tdata[7:0] == 8'd0)
    `JDM_ASSERT_IMPL(a_right_release, aclk, aresetn, m_tvalid && m_tdata[19:18] == jdm_pkg::DIR_RELEASE, m_tdata[17:10] == 8'd0)
    `JDM_ASSERT_IMPL(a_brush_pair, aclk, aresetn, m_tvalid, m_tdata[27:20] == (m_tdata[28] ? jdm_pkg::SPEED_MAX : 8'd0))
endmodule

// ----- tb/joystick_differential_drive_mixer_checker.sv -----
// Result predictor and comparator for the joystick drive mixer.
`timescale 1ns / 1ps
module joystick_differential_drive_mixer_checker
    import jdm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]         brush_lvl;
        logic [1:0]         right_dir;
        logic [7:0]         right_spd;
        logic [1:0]         left_dir;
        logic [7:0]         left_spd;
    } drive_cmd_t;

    typedef struct {
        logic [7:0] spd;
        dir_t       dir;
    } wheel_cmd_t;

    drive_cmd_t     drive_q[$];
    logic [10:0]    gain;

    // Largest q in [0,255] with (256q)^2 * sq <= (m*|num|)^2
    function automatic wheel_cmd_t wheel_speed(longint num, longint unsigned m,
                                               longint unsigned sq);
        wheel_cmd_t      w;
        longint unsigned mag;
        longint unsigned n2;
        longint unsigned q;
        longint unsigned t;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        n2  = (m * mag) * (m * mag);
        q   = 0;
        for (int b = 7; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t * t * 65536 * sq <= n2)
                q = t;
        end
        w.spd = q[7:0];
        if (q == 0)
            w.dir = DIR_RELEASE;
        else
            w.dir = (num > 0) ? DIR_FORWARD : DIR_BACKWARD;
        return w;
    endfunction

    function automatic drive_cmd_t mix_drive(logic [23:0] req, logic [10:0] g);
        drive_cmd_t      c;
        wheel_cmd_t      lw;
        wheel_cmd_t      rw;
        longint          xs;
        longint          ys;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        longint unsigned sq;
        xs = -longint'($signed(req[10:0]));
        ys = -longint'($signed(req[21:11]));
        ax = (xs < 0) ? -xs : xs;
        ay = (ys < 0) ? -ys : ys;
        m  = (ax > ay) ? ax : ay;
        sq = ax * ax + ay * ay;
        c  = '0;
        if (m != 0) begin
            lw = wheel_speed(ys * 256 + xs * longint'(g), m, sq);
            rw = wheel_speed(ys * 256 - xs * longint'(g), m, sq);
            c.left_spd  = lw.spd;
            c.left_dir  = lw.dir;
            c.right_spd = rw.spd;
            c.right_dir = rw.dir;
        end
        c.brush_lvl = req[22] ? SPEED_MAX : 8'd0;
        return c;
    endfunction

    always @(posedge aclk) begin
        drive_cmd_t want;
        logic [7:0] bspd;
        logic       bdir;
        if (!aresetn) begin
            gain       <= GAIN_RESET;
            fail_count <= 0;
            pending    <= 0;
            drive_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_TURN_GAIN)
                gain <= pwdata[10:0];
            if (s_tvalid && s_tready)
                drive_q.push_back(mix_drive(s_tdata, gain));
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    $error("result with no request pending");
                    fail_count <= fail_count + 1;
                end else begin
                    want = drive_q.pop_front();
                    bspd = want.brush_lvl;
                    bdir = (bspd != 0);
                    if (m_tdata[7:0] !== want.left_spd ||
                        m_tdata[9:8] !== want.left_dir ||
                        m_tdata[17:10] !== want.right_spd ||
                        m_tdata[19:18] !== want.right_dir ||
                        m_tdata[27:20] !== bspd || m_tdata[28] !== bdir)
                        fail_count <= fail_count + 1;
                    if (m_tdata[7:0] !== want.left_spd)
                        $error("left_speed exp %0d got %0d", want.left_spd, m_tdata[7:0]);
                    if (m_tdata[9:8] !== want.left_dir)
                        $error("left_direction exp %0d got %0d", want.left_dir, m_tdata[9:8]);
                    if (m_tdata[17:10] !== want.right_spd)
                        $error("right_speed exp %0d got %0d", want.right_spd,
                               m_tdata[17:10]);
                    if (m_tdata[19:18] !== want.right_dir)
                        $error("right_direction exp %0d got %0d", want.right_dir,
                               m_tdata[19:18]);
                    if (m_tdata[27:20] !== bspd)
                        $error("brush_speed exp %0d got %0d", bspd, m_tdata[27:20]);
                    if (m_tdata[28] !== bdir)
                        $error("brush_direction exp %0d got %0d", bdir, m_tdata[28]);
                end
            end
            pending <= drive_q.size();
        end
    end

endmodule

// ----- tb/joystick_differential_drive_mixer_unit_test.sv -----
// Stimulus and verdict for the joystick drive mixer.
`timescale 1ns / 1ps
module joystick_differential_drive_mixer_unit_test;
    import jdm_pkg::*;

    localparam int WATCHDOG = 2000;
    localparam int LATENCY  = 11;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    joystick_differential_drive_mixer_unit dut (.*);

    joystick_differential_drive_mixer_checker checker_i (.*);

    // Watchdog on accepted traffic
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side backpressure; random stalls, and some results see none
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic write_gain(logic [10:0] g);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {21'd0, g};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(logic [10:0] x, logic [10:0] y, logic brush, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, brush, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    function automatic logic [10:0] rand_axis();
        case ($urandom_range(0, 5))
            0:       return 11'($urandom_range(0, 2047));
            1:       return 11'($signed($urandom_range(0, 8)) - 4);
            default: return 11'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    initial begin
        logic [10:0] corner [8];
        logic [10:0] gains  [6];
        bit          burst;
        corner = '{11'h000, 11'd512, -11'sd512, 11'd1023, 11'h400, 11'd1, 11'h7FF, 11'd300};
        gains  = '{11'd0, 11'd1024, 11'd2047, 11'd1, 11'd128, 11'd700};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: corners at reset gain, then at extreme gains
        for (int i = 0; i < 8; i++)
            send_sample(corner[i], corner[(i * 3 + 1) % 8], i[0], 1'b0);
        send_sample(11'd0, 11'd0, 1'b1, 1'b0);
        send_sample(11'd5, 11'd0, 1'b0, 1'b0);
        drain();
        write_gain(11'd2047);
        send_sample(11'h400, 11'h400, 1'b1, 1'b0);
        send_sample(11'd512, 11'd0, 1'b0, 1'b0);
        send_sample(11'd3, 11'h7FF, 1'b1, 1'b0);
        drain();
        write_gain(11'd0);
        send_sample(11'd512, 11'd0, 1'b1, 1'b0);
        send_sample(11'd200, -11'sd100, 1'b0, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_gain(gains[ph]);
            for (int i = 0; i < 215; i++) begin
                burst = (i % 60) < 20;
                send_sample(rand_axis(), rand_axis(), 1'($urandom_range(0, 1)), burst);
            end
            drain();
        end
        write_gain(GAIN_RESET);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- joystick_differential_drive_mixer_unit.f -----
+incdir+rtl/core
rtl/core/jdm_pkg.sv
rtl/core/jdm_front.sv
rtl/core/jdm_cell.sv
rtl/core/joystick_differential_drive_mixer_unit.sv
tb/joystick_differential_drive_mixer_checker.sv
tb/joystick_differential_drive_mixer_unit_test.sv
